// File: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the postfix expression evaluator
// Word format, stack sizing, token and status codes, the request bundle for
// the arithmetic unit and the sign/magnitude saturation helpers.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // word format: signed fixed point, 48 bits
  localparam int VAL_W         = 48;
  localparam int FRACTION_BITS = 16;

  // operand stack sizing
  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int OP_W   = 3;
  localparam int STAT_W = 3;

  // token codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_END  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DIVZERO  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BADTOK   = 3'd4;
  localparam logic [STAT_W-1:0] STAT_LEFTOVER = 3'd5;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd6;

  // saturation limits
  localparam logic [VAL_W-1:0] MAX_VAL = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MIN_VAL = {1'b1, {(VAL_W-1){1'b0}}};

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_req_t;

  // absolute value of a two's complement word (most negative fits unsigned)
  function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? (~x + 1'b1) : x;
  endfunction

  // rebuild a signed word from sign and magnitude, clamping to the range
  function automatic logic [VAL_W-1:0] sat_mag(input logic neg, input logic big,
                                               input logic [VAL_W-1:0] mag);
    logic [VAL_W-1:0] r;
    if (!neg) begin
      r = (big || mag[VAL_W-1]) ? MAX_VAL : mag;
    end else begin
      r = (big || (mag[VAL_W-1] && (|mag[VAL_W-2:0]))) ? MIN_VAL : (~mag + 1'b1);
    end
    return r;
  endfunction

endpackage

// File: rtl/pfe_alu.sv
// ----------------------------------------------------------------------------
// pfe_alu: shared arithmetic unit
// Saturating add/subtract in one step, multiply as four 24x24 partial
// products accumulated over cycles, divide as a restoring bit-serial loop.
// ----------------------------------------------------------------------------
module pfe_alu import pfe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  alu_req_t         req,
  input  logic [VAL_W-1:0] opa,
  input  logic [VAL_W-1:0] opb,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  localparam int HALF_W = VAL_W / 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DVD_W  = VAL_W + FRACTION_BITS;
  localparam int ITER_W = $clog2(DVD_W + 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_ADD  = 3'd1;
  localparam logic [2:0] A_MUL  = 3'd2;
  localparam logic [2:0] A_MFIN = 3'd3;
  localparam logic [2:0] A_DIV  = 3'd4;
  localparam logic [2:0] A_DFIN = 3'd5;

  logic [2:0]        state;
  logic              op_sub;
  logic              neg;
  logic [VAL_W-1:0]  opa_r;
  logic [VAL_W-1:0]  opb_r;
  logic [VAL_W-1:0]  mag_a;
  logic [VAL_W-1:0]  mag_b;
  logic [2:0]        cnt;
  logic [VAL_W-1:0]  prod;
  logic [1:0]        psh;
  logic [PROD_W-1:0] acc;
  logic [DVD_W-1:0]  dvd;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  quo;
  logic              big;
  logic [ITER_W-1:0] iter;

  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  sum_sat;
  logic [HALF_W-1:0] pa;
  logic [HALF_W-1:0] pb;
  logic [VAL_W-1:0]  prod_c;
  logic [PROD_W-1:0] prod_shifted;
  logic [PROD_W-1:0] mul_full;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    rem_diff;
  logic              fits;

  // add/subtract on 49 bits, then clamp
  always_comb begin
    if (op_sub) begin
      sum = {opa_r[VAL_W-1], opa_r} - {opb_r[VAL_W-1], opb_r};
    end else begin
      sum = {opa_r[VAL_W-1], opa_r} + {opb_r[VAL_W-1], opb_r};
    end
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sum_sat = sum[VAL_W] ? MIN_VAL : MAX_VAL;
    end else begin
      sum_sat = sum[VAL_W-1:0];
    end
  end

  // partial product select and alignment
  assign pa     = cnt[1] ? mag_a[VAL_W-1:HALF_W] : mag_a[HALF_W-1:0];
  assign pb     = cnt[0] ? mag_b[VAL_W-1:HALF_W] : mag_b[HALF_W-1:0];
  assign prod_c = pa * pb;

  always_comb begin
    case (psh)
      2'd0:    prod_shifted = PROD_W'(prod);
      2'd1:    prod_shifted = PROD_W'(prod) << HALF_W;
      default: prod_shifted = PROD_W'(prod) << VAL_W;
    endcase
  end

  assign mul_full = acc >> FRACTION_BITS;

  // one restoring division step
  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, mag_b};
  assign rem_diff = rem_sh - {1'b0, mag_b};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            opa_r  <= opa;
            opb_r  <= opb;
            mag_a  <= magnitude(opa);
            mag_b  <= magnitude(opb);
            neg    <= opa[VAL_W-1] ^ opb[VAL_W-1];
            op_sub <= (req.op == OP_SUB);
            cnt    <= 3'd0;
            acc    <= '0;
            dvd    <= DVD_W'(magnitude(opa)) << FRACTION_BITS;
            rem    <= '0;
            quo    <= '0;
            big    <= 1'b0;
            iter   <= '0;
            if (req.op == OP_MUL) begin
              state <= A_MUL;
            end else if (req.op == OP_DIV) begin
              state <= A_DIV;
            end else begin
              state <= A_ADD;
            end
          end
        end
        A_ADD: begin
          result <= sum_sat;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_MUL: begin
          // product of step n is accumulated in step n+1
          if (cnt != 3'd4) begin
            prod <= prod_c;
            psh  <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
          end
          if (cnt != 3'd0) begin
            acc <= acc + prod_shifted;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            state <= A_MFIN;
          end
        end
        A_MFIN: begin
          result <= sat_mag(neg, |mul_full[PROD_W-1:VAL_W], mul_full[VAL_W-1:0]);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_DIV: begin
          rem  <= fits ? rem_diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
          quo  <= {quo[VAL_W-2:0], fits};
          big  <= big | quo[VAL_W-1];
          dvd  <= dvd << 1;
          iter <= iter + 1'b1;
          if (iter == ITER_W'(DVD_W - 1)) begin
            state <= A_DFIN;
          end
        end
        A_DFIN: begin
          result <= sat_mag(neg, big, quo);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top: token-at-a-time postfix evaluator
// Operand stack, token sequencer and output register around a shared
// arithmetic unit.
// ----------------------------------------------------------------------------
// Tokens (operation, operand_value) arrive on a valid/ready input channel;
// results (status, result_value) leave on a valid/ready output channel, at
// most one per token. Only an end token or an error produces a result.
// Sequencer states that each token passes through after its transfer:
//   push, dropped token, end without result: none, stays in S_IDLE
//   token with an error result: S_EMIT; successful end: S_END, S_EMIT;
//   divide by zero: S_EXEC, S_EMIT; add/subtract, multiply (four 24x24
//   partial products on the shared unit), divide: S_EXEC, S_ALU, with
//   one quotient bit per cycle in the shared unit for Q32.16 words
// A result is staged in the sequencer, then loaded into the output
// register from S_EMIT once that register is free.
// Reset empties the stack, clears the error and token flags and drops any
// pending result; stack contents are not cleared and need no clearing pass.
// A stalled receiver holds the result in the output register; tokens are
// still taken until another result needs the register, then the block
// waits with in_ready low until the pending result transfers.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_top import pfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [VAL_W-1:0] operand_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STAT_W-1:0]       status,
  output logic signed [VAL_W-1:0] result_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ALU  = 3'd2;
  localparam logic [2:0] S_END  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic              dropping;
  logic              token_seen;
  logic [OP_W-1:0]   op_r;
  logic [STAT_W-1:0] res_status;
  logic [VAL_W-1:0]  res_value;

  logic [VAL_W-1:0]  stack_mem [STACK_DEPTH];
  logic [VAL_W-1:0]  rd_a;
  logic [VAL_W-1:0]  rd_b;

  logic              accept;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [PTR_W-1:0]  addr_a;
  logic [PTR_W-1:0]  addr_b;
  logic              push_ok;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              emit_load;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [VAL_W-1:0]  alu_result;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // top-of-stack addresses
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);
  assign addr_b = cnt_m1[PTR_W-1:0];
  assign addr_a = cnt_m2[PTR_W-1:0];

  // stack write: push on transfer, operator result on unit completion
  assign push_ok   = accept && (operation == OP_PUSH) && !dropping
                     && (count < CNT_W'(STACK_DEPTH));
  assign mem_we    = push_ok || ((state == S_ALU) && alu_done);
  assign mem_waddr = (state == S_ALU) ? addr_a : count[PTR_W-1:0];
  assign mem_wdata = (state == S_ALU) ? alu_result : operand_value;

  // operand stack memory, registered reads of the two top entries
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_a <= stack_mem[addr_a];
    rd_b <= stack_mem[addr_b];
  end

  // arithmetic unit request
  assign alu_req.start = (state == S_EXEC) && !((op_r == OP_DIV) && (rd_b == '0));
  assign alu_req.op    = op_r;

  pfe_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (rd_a),
    .opb    (rd_b),
    .done   (alu_done),
    .result (alu_result)
  );

  // token sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      dropping   <= 1'b0;
      token_seen <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OP_END) begin
              count      <= '0;
              dropping   <= 1'b0;
              token_seen <= 1'b0;
              if (dropping) begin
                state <= S_IDLE;
              end else if (!token_seen) begin
                res_status <= STAT_EMPTY;
                res_value  <= '0;
                state      <= S_EMIT;
              end else if (count != CNT_W'(1)) begin
                res_status <= STAT_LEFTOVER;
                res_value  <= '0;
                state      <= S_EMIT;
              end else begin
                state <= S_END;
              end
            end else if (!dropping) begin
              token_seen <= 1'b1;
              case (operation)
                OP_PUSH: begin
                  if (count >= CNT_W'(STACK_DEPTH)) begin
                    dropping   <= 1'b1;
                    res_status <= STAT_OVERFLOW;
                    res_value  <= '0;
                    state      <= S_EMIT;
                  end else begin
                    count <= count + CNT_W'(1);
                  end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (count < CNT_W'(2)) begin
                    dropping   <= 1'b1;
                    res_status <= STAT_MISSING;
                    res_value  <= '0;
                    state      <= S_EMIT;
                  end else begin
                    op_r  <= operation;
                    state <= S_EXEC;
                  end
                end
                default: begin
                  dropping   <= 1'b1;
                  res_status <= STAT_BADTOK;
                  res_value  <= '0;
                  state      <= S_EMIT;
                end
              endcase
            end
          end
        end
        S_EXEC: begin
          // operands were read at the token transfer
          if ((op_r == OP_DIV) && (rd_b == '0)) begin
            dropping   <= 1'b1;
            res_status <= STAT_DIVZERO;
            res_value  <= '0;
            state      <= S_EMIT;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            count <= cnt_m1;
            state <= S_IDLE;
          end
        end
        S_END: begin
          res_status <= STAT_OK;
          res_value  <= rd_b;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  assign emit_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      status       <= res_status;
      result_value <= res_value;
    end
  end

endmodule
